/* hdl/sipt_pkg.sv */
// shared types and constants of the segment inside polygon test
package sipt_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VADDR_W = $clog2(MAX_VERTICES);
   localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W = 16;
   localparam int VDATA_W = 2 * COORD_W;
   localparam int WIDE_W = 22;
   localparam int PROD_W = 2 * WIDE_W;
   localparam int ORI_W = PROD_W + 1;
   localparam int STEP_W = 3;
   localparam int MCNT_W = 4;
   localparam int MATH_LAST = 9;
   localparam int ISSUE_STEPS = 8;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_TEST   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PASS_START = 2'd0,
      PASS_END   = 2'd1,
      PASS_CROSS = 2'd2,
      PASS_MID   = 2'd3
   } pass_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR_A,
      ST_ADDR_B,
      ST_LATCH_B,
      ST_MATH,
      ST_EVAL,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic              vld;
      logic [STEP_W-1:0] step;
   } ori_ctrl_type;

   typedef struct packed {
      logic       vld;
      logic [1:0] idx;
      logic       neg;
      logic       zero;
   } ori_res_type;

endpackage

/* hdl/sipt_ifs.sv */
// request and response channel interfaces
interface sipt_req_if import sipt_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] action;
   coord_type  start_x;
   coord_type  start_y;
   coord_type  end_x;
   coord_type  end_y;

   modport source(output valid, action, start_x, start_y, end_x, end_y, input ready);
   modport sink(input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface sipt_rsp_if ();
   logic valid;
   logic ready;
   logic inside_res;
   logic overflowed;

   modport source(output valid, inside_res, overflowed, input ready);
   modport sink(input valid, inside_res, overflowed, output ready);
endinterface

/* hdl/sipt_ram.sv */
// generic single write port ram with registered read
module sipt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sipt_orient_unit.sv */
// shared multiply and subtract unit giving orientation signs
module sipt_orient_unit import sipt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ori_ctrl_type op_ctrl,
   input  wide_type     op_u,
   input  wide_type     op_v,
   output ori_res_type  res
);

   wide_type                   u_ff;
   wide_type                   v_ff;
   ori_ctrl_type               c1_ff;
   ori_ctrl_type               c2_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   acc_ff;
   logic signed [ORI_W-1:0]    diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
      end else begin
         c1_ff <= op_ctrl;
         c2_ff <= c1_ff;
      end
      u_ff    <= op_u;
      v_ff    <= op_v;
      prod_ff <= u_ff * v_ff;
      // even steps hold the first product of an orientation
      if (c2_ff.vld && !c2_ff.step[0]) begin
         acc_ff <= prod_ff;
      end
   end

   assign diff     = ORI_W'(acc_ff) - ORI_W'(prod_ff);
   assign res.vld  = c2_ff.vld && c2_ff.step[0];
   assign res.idx  = c2_ff.step[STEP_W-1:1];
   assign res.neg  = diff[ORI_W-1];
   assign res.zero = (diff == '0);

endmodule

/* hdl/segment_inside_polygon_test_unit.sv */
// segment inside polygon test: vertex store, sequencer and top level
// load beats are taken in the idle state; a test with no polygon goes straight to the reply
// a test beat runs 4 passes over the n stored edges: read a and b, math, evaluate, per edge
// the one shared 22x22 multiplier (8 products per edge) and the ram read port serve each edge
// throughput: one test at a time, req ready only when idle; a held response stalls only the next reply
// reset: synchronous, clears vertex count, min/max x and drop flag; vertex ram is not cleared
module segment_inside_polygon_test_unit import sipt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   sipt_req_if.sink          req_if,
   sipt_rsp_if.source        rsp_if
);

   // sequencer state
   state_type             state_ff, state_in;
   pass_type              pass_ff, pass_in;
   logic [VADDR_W-1:0]    edge_ff, edge_in;
   logic [MCNT_W-1:0]     mcnt_ff, mcnt_in;

   // polygon state
   logic [VCNT_W-1:0]     vcount_ff, vcount_in;
   coord_type             least_ff, least_in;
   coord_type             greatest_ff, greatest_in;
   logic                  dropped_ff, dropped_in;

   // captured test segment
   coord_type             sx_ff, sy_ff, ex_ff, ey_ff;

   // working points: p and q of the probe segment, a and b of the edge
   wide_type              px_ff, py_ff, qx_ff, qy_ff;
   wide_type              ax_ff, ay_ff, bx_ff, by_ff;
   wide_type              px_in, py_in, qx_in, qy_in;

   // orientation signs and pass flags
   logic [3:0]            o_neg_ff, o_zero_ff;
   logic                  parity_ff, parity_in;
   logic                  on_edge_ff, on_edge_in;
   logic                  crossed_ff, crossed_in;
   logic                  ok_ff, ok_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_inside_ff, rsp_ovf_ff;
   logic                  rsp_load;

   // ram port
   logic                  wr_en;
   logic [VADDR_W-1:0]    wr_addr;
   logic [VDATA_W-1:0]    rd_data;
   logic [VADDR_W-1:0]    rd_addr;

   // derived
   logic                  req_beat;
   action_type            req_action;
   logic                  last_edge;
   logic [VADDR_W-1:0]    next_edge;
   logic                  double;
   wide_type              rd_x, rd_y;
   wide_type              mx, mn, far_x;

   ori_ctrl_type          op_ctrl;
   wide_type              op_u, op_v;
   ori_res_type           ori_res;
   wide_type              oa_x, oa_y, ob_x, ob_y, oc_x, oc_y;

   wide_type              d1x, d1y, d2x, d2y;
   logic                  x_ok, y_ok, on_now, proper_now;
   logic                  parity_new, on_edge_new, crossed_new, pass_ok;

   assign req_action = action_type'(req_if.action);
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_beat = req_if.valid && req_if.ready;

   assign last_edge = (edge_ff == VADDR_W'(vcount_ff - VCNT_W'(1)));
   assign next_edge = last_edge ? '0 : edge_ff + VADDR_W'(1);
   assign double = (pass_ff == PASS_MID);

   // vertex store, x in the upper half
   assign wr_en = req_beat && ((req_action == ACT_START) ||
                  ((req_action == ACT_APPEND) && (vcount_ff < VCNT_W'(MAX_VERTICES))));
   assign wr_addr = (req_action == ACT_START) ? '0 : vcount_ff[VADDR_W-1:0];
   assign rd_addr = (state_ff == ST_ADDR_B) ? next_edge : edge_ff;

   sipt_ram #(
      .WIDTH(VDATA_W),
      .DEPTH(MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_if.start_x, req_if.start_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // scale vertex read by two in the midpoint pass
   always_comb begin
      rd_x = WIDE_W'($signed(rd_data[VDATA_W-1:COORD_W]));
      rd_y = WIDE_W'($signed(rd_data[COORD_W-1:0]));
      if (double) begin
         rd_x = rd_x <<< 1;
         rd_y = rd_y <<< 1;
      end
   end

   // far point x: mx + 2*(mx - mn) + 1
   always_comb begin
      mx = WIDE_W'(greatest_ff);
      mn = WIDE_W'(least_ff);
      if (double) begin
         mx = mx <<< 1;
         mn = mn <<< 1;
      end
      far_x = mx + ((mx - mn) <<< 1) + WIDE_W'(1);
   end

   // probe segment per pass
   always_comb begin
      px_in = WIDE_W'(sx_ff);
      py_in = WIDE_W'(sy_ff);
      qx_in = far_x;
      qy_in = WIDE_W'(sy_ff) + WIDE_W'(1);
      unique case (pass_ff)
         PASS_START: begin
         end
         PASS_END: begin
            px_in = WIDE_W'(ex_ff);
            py_in = WIDE_W'(ey_ff);
            qy_in = WIDE_W'(ey_ff) + WIDE_W'(1);
         end
         PASS_CROSS: begin
            qx_in = WIDE_W'(ex_ff);
            qy_in = WIDE_W'(ey_ff);
         end
         PASS_MID: begin
            px_in = WIDE_W'(sx_ff) + WIDE_W'(ex_ff);
            py_in = WIDE_W'(sy_ff) + WIDE_W'(ey_ff);
            qy_in = WIDE_W'(sy_ff) + WIDE_W'(ey_ff) + WIDE_W'(1);
         end
         default: begin
         end
      endcase
   end

   // operand select: orientations (p,q,a) (p,q,b) (a,b,p) (a,b,q), two products each
   always_comb begin
      oa_x = px_ff;
      oa_y = py_ff;
      ob_x = qx_ff;
      ob_y = qy_ff;
      oc_x = ax_ff;
      oc_y = ay_ff;
      unique case (mcnt_ff[STEP_W-1:1])
         2'd0: begin
         end
         2'd1: begin
            oc_x = bx_ff;
            oc_y = by_ff;
         end
         2'd2: begin
            oa_x = ax_ff;
            oa_y = ay_ff;
            ob_x = bx_ff;
            ob_y = by_ff;
            oc_x = px_ff;
            oc_y = py_ff;
         end
         default: begin
            oa_x = ax_ff;
            oa_y = ay_ff;
            ob_x = bx_ff;
            ob_y = by_ff;
            oc_x = qx_ff;
            oc_y = qy_ff;
         end
      endcase
      if (mcnt_ff[0]) begin
         op_u = ob_y - oa_y;
         op_v = oc_x - oa_x;
      end else begin
         op_u = ob_x - oa_x;
         op_v = oc_y - oa_y;
      end
      op_ctrl.vld  = (state_ff == ST_MATH) && (mcnt_ff < MCNT_W'(ISSUE_STEPS));
      op_ctrl.step = mcnt_ff[STEP_W-1:0];
   end

   sipt_orient_unit u_orient (
      .clock   (clock),
      .reset   (reset),
      .op_ctrl (op_ctrl),
      .op_u    (op_u),
      .op_v    (op_v),
      .res     (ori_res)
   );

   // edge evaluation
   always_comb begin
      d1x = ax_ff - px_ff;
      d1y = ay_ff - py_ff;
      d2x = bx_ff - px_ff;
      d2y = by_ff - py_ff;
      x_ok = (d1x == '0) || (d2x == '0) || (d1x[WIDE_W-1] != d2x[WIDE_W-1]);
      y_ok = (d1y == '0) || (d2y == '0) || (d1y[WIDE_W-1] != d2y[WIDE_W-1]);
      // orientation (a,b,p) equals the cross product of a-p and b-p
      on_now = o_zero_ff[2] && x_ok && y_ok;
      proper_now = !o_zero_ff[0] && !o_zero_ff[1] && (o_neg_ff[0] != o_neg_ff[1]) &&
                   !o_zero_ff[2] && !o_zero_ff[3] && (o_neg_ff[2] != o_neg_ff[3]);
      parity_new  = parity_ff ^ proper_now;
      on_edge_new = on_edge_ff || on_now;
      crossed_new = crossed_ff || proper_now;
      pass_ok = (pass_ff == PASS_CROSS) ? !crossed_new : (on_edge_new || parity_new);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_action == ACT_TEST)) begin
               state_in = (vcount_ff == '0) ? ST_REPLY : ST_ADDR_A;
            end
         end
         ST_ADDR_A:  state_in = ST_ADDR_B;
         ST_ADDR_B:  state_in = ST_LATCH_B;
         ST_LATCH_B: state_in = ST_MATH;
         ST_MATH: begin
            if (mcnt_ff == MCNT_W'(MATH_LAST)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = (last_edge && (pass_ff == PASS_MID)) ? ST_REPLY : ST_ADDR_A;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      pass_in     = pass_ff;
      edge_in     = edge_ff;
      mcnt_in     = '0;
      vcount_in   = vcount_ff;
      least_in    = least_ff;
      greatest_in = greatest_ff;
      dropped_in  = dropped_ff;
      parity_in   = parity_ff;
      on_edge_in  = on_edge_ff;
      crossed_in  = crossed_ff;
      ok_in       = ok_ff;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               unique case (req_action)
                  ACT_START: begin
                     vcount_in   = VCNT_W'(1);
                     least_in    = req_if.start_x;
                     greatest_in = req_if.start_x;
                     dropped_in  = 1'b0;
                  end
                  ACT_APPEND: begin
                     if (vcount_ff >= VCNT_W'(MAX_VERTICES)) begin
                        dropped_in = 1'b1;
                     end else begin
                        vcount_in = vcount_ff + VCNT_W'(1);
                        if (vcount_ff == '0) begin
                           least_in    = req_if.start_x;
                           greatest_in = req_if.start_x;
                        end else begin
                           if (req_if.start_x < least_ff) begin
                              least_in = req_if.start_x;
                           end
                           if (req_if.start_x > greatest_ff) begin
                              greatest_in = req_if.start_x;
                           end
                        end
                     end
                  end
                  ACT_TEST: begin
                     pass_in    = PASS_START;
                     edge_in    = '0;
                     parity_in  = 1'b0;
                     on_edge_in = 1'b0;
                     crossed_in = 1'b0;
                     ok_in      = (vcount_ff != '0);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MATH: begin
            mcnt_in = mcnt_ff + MCNT_W'(1);
         end
         ST_EVAL: begin
            parity_in  = parity_new;
            on_edge_in = on_edge_new;
            crossed_in = crossed_new;
            edge_in    = next_edge;
            if (last_edge) begin
               ok_in      = ok_ff && pass_ok;
               pass_in    = pass_type'(pass_ff + 2'd1);
               parity_in  = 1'b0;
               on_edge_in = 1'b0;
               crossed_in = 1'b0;
            end
         end
         ST_REPLY: begin
            rsp_load = !rsp_valid_ff || rsp_if.ready;
         end
         default: begin
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_START;
         edge_ff      <= '0;
         mcnt_ff      <= '0;
         vcount_ff    <= '0;
         least_ff     <= '0;
         greatest_ff  <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         edge_ff      <= edge_in;
         mcnt_ff      <= mcnt_in;
         vcount_ff    <= vcount_in;
         least_ff     <= least_in;
         greatest_ff  <= greatest_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      parity_ff  <= parity_in;
      on_edge_ff <= on_edge_in;
      crossed_ff <= crossed_in;
      ok_ff      <= ok_in;
      if (req_beat) begin
         sx_ff <= req_if.start_x;
         sy_ff <= req_if.start_y;
         ex_ff <= req_if.end_x;
         ey_ff <= req_if.end_y;
      end
      if (state_ff == ST_ADDR_A) begin
         px_ff <= px_in;
         py_ff <= py_in;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
      end
      if (state_ff == ST_ADDR_B) begin
         ax_ff <= rd_x;
         ay_ff <= rd_y;
      end
      if (state_ff == ST_LATCH_B) begin
         bx_ff <= rd_x;
         by_ff <= rd_y;
      end
      if (ori_res.vld) begin
         o_neg_ff[ori_res.idx]  <= ori_res.neg;
         o_zero_ff[ori_res.idx] <= ori_res.zero;
      end
      if (rsp_load) begin
         rsp_inside_ff <= ok_ff;
         rsp_ovf_ff    <= dropped_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.inside_res = rsp_inside_ff;
   assign rsp_if.overflowed = rsp_ovf_ff;

   // vertex count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= VCNT_W'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   // orientation results only arrive while the edge math runs
   a_ori_in_math: assert property (@(posedge clock) disable iff (reset)
      ori_res.vld |-> (state_ff == ST_MATH))
      else $error("orientation result outside math phase");

   // a test on a loaded polygon starts the first pass at edge zero
   a_test_start: assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_action == ACT_TEST) && (vcount_ff != '0)) |=>
      (state_ff == ST_ADDR_A) && (pass_ff == PASS_START) && (edge_ff == '0))
      else $error("test did not start at first pass");

   // drop flag rises only on an append to a full store
   a_drop_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(dropped_ff) |-> ($past(vcount_ff) == VCNT_W'(MAX_VERTICES)))
      else $error("drop flag set without full store");

endmodule

/* bench/sipt_tb_pkg.sv */
// beat types shared by the stimulus and the checker
package sipt_tb_pkg;
   import sipt_pkg::*;

   typedef struct packed {
      action_type action;
      coord_type  start_x;
      coord_type  start_y;
      coord_type  end_x;
      coord_type  end_y;
   } req_beat_type;

   typedef struct packed {
      logic inside_res;
      logic overflowed;
   } rsp_beat_type;
endpackage

/* bench/sipt_tb_ifs.sv */
// watch-only view of the two channels for the checker
interface sipt_tb_watch_if import sipt_tb_pkg::*; ();
   logic         req_fire;
   req_beat_type req_beat;
   logic         rsp_fire;
   rsp_beat_type rsp_beat;
endinterface

/* bench/sipt_checker.sv */
// polygon shadow, inside prediction and response comparison
module sipt_checker import sipt_pkg::*; import sipt_tb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  req_beat_type req_beat,
   input  logic         rsp_fire,
   input  rsp_beat_type rsp_beat,
   output int           fail_count,
   output int           pending
);
   longint       poly_x [MAX_VERTICES];
   longint       poly_y [MAX_VERTICES];
   int           poly_n;
   longint       min_x, max_x;
   logic         dropped;
   rsp_beat_type verdicts [$];

   function automatic longint orient(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
      return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
   endfunction

   function automatic bit opp(longint a, longint b);
      return (a < 0 && b > 0) || (a > 0 && b < 0);
   endfunction

   function automatic bit crosses(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy, longint dx, longint dy);
      return opp(orient(ax, ay, bx, by, cx, cy), orient(ax, ay, bx, by, dx, dy)) &&
             opp(orient(cx, cy, dx, dy, ax, ay), orient(cx, cy, dx, dy, bx, by));
   endfunction

   function automatic bit point_in(longint s, longint px, longint py);
      longint ox, oy, ax, ay, bx, by, d1x, d1y, d2x, d2y;
      int     j, hits;
      hits = 0;
      ox = max_x * s + (max_x * s - min_x * s) * 2 + 1;
      oy = py + 1;
      if (poly_n == 0) return 0;
      for (int i = 0; i < poly_n; i++) begin
         j = (i + 1 == poly_n) ? 0 : i + 1;
         ax = poly_x[i] * s; ay = poly_y[i] * s;
         bx = poly_x[j] * s; by = poly_y[j] * s;
         d1x = ax - px; d1y = ay - py; d2x = bx - px; d2y = by - py;
         if (d1x * d2y - d1y * d2x == 0 && d1x * d2x <= 0 && d1y * d2y <= 0) return 1;
         if (crosses(px, py, ox, oy, ax, ay, bx, by)) hits++;
      end
      return hits[0];
   endfunction

   function automatic bit segment_in(longint x0, longint y0, longint x1, longint y1);
      int j;
      if (poly_n == 0) return 0;
      if (!point_in(1, x0, y0) || !point_in(1, x1, y1)) return 0;
      for (int i = 0; i < poly_n; i++) begin
         j = (i + 1 == poly_n) ? 0 : i + 1;
         if (crosses(x0, y0, x1, y1, poly_x[i], poly_y[i], poly_x[j], poly_y[j])) return 0;
      end
      return point_in(2, x0 + x1, y0 + y1);
   endfunction

   assign pending = verdicts.size();

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         poly_n = 0; min_x = 0; max_x = 0; dropped = 0;
         fail_count = 0;
         verdicts.delete();
      end else begin
         if (req_fire) begin
            case (req_beat.action)
               ACT_START: begin
                  poly_x[0] = req_beat.start_x; poly_y[0] = req_beat.start_y;
                  poly_n = 1; min_x = req_beat.start_x; max_x = req_beat.start_x;
                  dropped = 0;
               end
               ACT_APPEND: begin
                  if (poly_n >= MAX_VERTICES) dropped = 1;
                  else begin
                     poly_x[poly_n] = req_beat.start_x; poly_y[poly_n] = req_beat.start_y;
                     if (poly_n == 0) begin
                        min_x = req_beat.start_x; max_x = req_beat.start_x;
                     end else begin
                        if (req_beat.start_x < min_x) min_x = req_beat.start_x;
                        if (req_beat.start_x > max_x) max_x = req_beat.start_x;
                     end
                     poly_n++;
                  end
               end
               ACT_TEST: begin
                  want.inside_res = segment_in(req_beat.start_x, req_beat.start_y,
                                               req_beat.end_x, req_beat.end_y);
                  want.overflowed = dropped;
                  verdicts = {verdicts, want};
               end
               default: ;
            endcase
         end
         if (rsp_fire) begin
            if (verdicts.size() == 0) begin
               $error("unexpected response beat");
               fail_count = fail_count + 1;
            end else begin
               want = verdicts.pop_front();
               if (want.inside_res !== rsp_beat.inside_res) begin
                  $error("inside_res expected %0b actual %0b", want.inside_res,
                         rsp_beat.inside_res);
                  fail_count = fail_count + 1;
               end
               if (want.overflowed !== rsp_beat.overflowed) begin
                  $error("overflowed expected %0b actual %0b", want.overflowed,
                         rsp_beat.overflowed);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* bench/tb_segment_inside_polygon_test_unit.sv */
// stimulus and verdict for the segment inside polygon test unit
module tb_segment_inside_polygon_test_unit;
   import sipt_pkg::*;
   import sipt_tb_pkg::*;

   localparam int RANDOM_BEATS = 2000;
   // several times the slowest test on a full store of MAX_VERTICES, plus gaps
   localparam int STALL_LIMIT = 40000;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending, idle_cycles;

   sipt_req_if req_if ();
   sipt_rsp_if rsp_if ();
   sipt_tb_watch_if watch ();

   segment_inside_polygon_test_unit dut (
      .clock (clock), .reset (reset), .req_if (req_if.sink), .rsp_if (rsp_if.source)
   );

   // watcher samples handshakes at the rising edge
   assign watch.req_fire = req_if.valid && req_if.ready;
   assign watch.req_beat = '{action_type'(req_if.action), req_if.start_x, req_if.start_y,
                             req_if.end_x, req_if.end_y};
   assign watch.rsp_fire = rsp_if.valid && rsp_if.ready;
   assign watch.rsp_beat = '{rsp_if.inside_res, rsp_if.overflowed};

   sipt_checker u_checker (
      .clock (clock), .reset (reset),
      .req_fire (watch.req_fire), .req_beat (watch.req_beat),
      .rsp_fire (watch.rsp_fire), .rsp_beat (watch.rsp_beat),
      .fail_count (fail_count), .pending (pending)
   );

   always #6 clock = ~clock;

   // watchdog: cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || watch.req_fire || watch.rsp_fire) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // sink side: random stall per beat, with calm stretches
   initial begin
      int stall;
      bit calm;
      rsp_if.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         calm = ($urandom_range(0, 3) == 0);
         stall = calm ? 0 : $urandom_range(0, 19);
         rsp_if.ready <= 0;
         repeat (stall) @(negedge clock);
         rsp_if.ready <= 1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic coord_type any_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         default: return coord_type'($urandom());
      endcase
   endfunction

   // small coordinates keep segments near the polygon
   function automatic coord_type near_coord();
      return coord_type'($signed($urandom_range(0, 40)) - 20);
   endfunction

   task automatic send(action_type act, coord_type sx, coord_type sy,
                       coord_type ex, coord_type ey);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      repeat (gap) @(negedge clock);
      req_if.valid   <= 1;
      req_if.action  <= act;
      req_if.start_x <= sx; req_if.start_y <= sy;
      req_if.end_x   <= ex; req_if.end_y   <= ey;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      req_if.valid <= 0;
   endtask

   task automatic send_polygon(int n, bit wide);
      for (int i = 0; i < n; i++) begin
         if (wide) send(i == 0 ? ACT_START : ACT_APPEND, any_coord(), any_coord(), 0, 0);
         else send(i == 0 ? ACT_START : ACT_APPEND, near_coord(), near_coord(),
                   any_coord(), any_coord());
      end
   endtask

   initial begin
      int sent, n;
      req_if.valid = 0; req_if.action = ACT_NONE;
      req_if.start_x = 0; req_if.start_y = 0; req_if.end_x = 0; req_if.end_y = 0;
      repeat (9) @(negedge clock);
      reset <= 0;

      // empty polygon, append before start, action code 3
      send(ACT_TEST, 0, 0, 1, 1);
      send(ACT_APPEND, 16'sh8000, 16'sh7fff, 0, 0);
      send(ACT_APPEND, 16'sh7fff, 16'sh7fff, 0, 0);
      send(ACT_APPEND, 16'sh7fff, 16'sh8000, 0, 0);
      send(ACT_NONE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      // extremes against a full-range triangle
      send(ACT_TEST, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send(ACT_TEST, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
      send(ACT_TEST, 0, 0, 16'sh7fff, 0);
      // square with on-edge and crossing segments
      send(ACT_START, 0, 0, 0, 0);
      send(ACT_APPEND, 10, 0, 0, 0);
      send(ACT_APPEND, 10, 10, 0, 0);
      send(ACT_APPEND, 0, 10, 0, 0);
      send(ACT_TEST, 0, 0, 10, 10);
      send(ACT_TEST, 0, 5, 10, 5);
      send(ACT_TEST, -5, 5, 5, 5);
      send(ACT_TEST, 0, 0, 10, 0);
      // overflow: fill the store and push one past
      send_polygon(MAX_VERTICES + 1, 1);
      send(ACT_TEST, 1, 2, 3, 4);
      send(ACT_START, 1, 1, 0, 0);
      send(ACT_TEST, 1, 1, 1, 1);

      // hold until every verdict is back
      while (pending != 0) @(negedge clock);

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         // mostly small polygons with tests near them, some noise
         case ($urandom_range(0, 9))
            0: begin send(action_type'($urandom_range(0, 3)), any_coord(), any_coord(),
                          any_coord(), any_coord()); sent++; end
            1: begin n = ($urandom_range(0, 7) == 0) ? MAX_VERTICES + $urandom_range(0, 2)
                                                     : $urandom_range(3, 8);
                     send_polygon(n, $urandom_range(0, 1)); sent += n; end
            default: begin
               if ($urandom_range(0, 1))
                  send(ACT_TEST, near_coord(), near_coord(), near_coord(), near_coord());
               else
                  send(ACT_TEST, any_coord(), any_coord(), any_coord(), any_coord());
               sent++;
            end
         endcase
         if ($urandom_range(0, 150) == 0)
            while (pending != 0) @(negedge clock);
      end

      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

/* files.f */
hdl/sipt_pkg.sv
hdl/sipt_ifs.sv
hdl/sipt_ram.sv
hdl/sipt_orient_unit.sv
hdl/segment_inside_polygon_test_unit.sv
bench/sipt_tb_pkg.sv
bench/sipt_tb_ifs.sv
bench/sipt_checker.sv
bench/tb_segment_inside_polygon_test_unit.sv
